>>> rtl/core/pid_motor_speed_controller_defines.svh
// Assertion macros shared by the checking code of the motor speed controller.
`ifndef PID_MOTOR_SPEED_CONTROLLER_DEFINES_SVH
`define PID_MOTOR_SPEED_CONTROLLER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PMSC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PMSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/pmsc_pkg.sv
// Types and constants shared by the motor speed controller modules.
`timescale 1ns / 1ps

package pmsc_pkg;

  localparam int GAIN_W     = 16;
  localparam int SPAN_W     = 32;
  localparam int TGT_W      = 16;
  localparam int BUDGET_W   = 16;
  localparam int MEAS_W     = 16;
  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MPLIER_W   = 16;
  localparam int FRAC_BITS  = 8;
  localparam int TERMS      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_FLOOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_CEILING = 3'd4;

  localparam logic signed [GAIN_W-1:0] GAIN_P_RESET      = 16'sd256;
  localparam logic signed [SPAN_W-1:0] SUM_CEILING_RESET = 32'sd65535;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_EDGE   = 2'd0,
    FUNC_TICK   = 2'd1,
    FUNC_TARGET = 2'd2,
    FUNC_BRAKE  = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_INT,
    S_LOAD,
    S_MUL,
    S_CMP,
    S_RNG,
    S_SCALE,
    S_DIVLD,
    S_DIV,
    S_QUOT,
    S_DONE,
    S_REPORT
  } state_t;

  typedef struct packed {
    logic clear;
    logic load_mul;
    logic msigned;
    logic mul_step;
    logic load_div;
    logic div_step;
  } alu_ctrl_t;

endpackage

>>> rtl/core/pmsc_alu.sv
// Shared shift-add multiplier-accumulator and restoring divider of the controller.
`timescale 1ns / 1ps

module pmsc_alu #(
  parameter int ACC_W     = 64,
  parameter int DUTY_BITS = 10
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  pmsc_pkg::alu_ctrl_t                   ctrl,
  input  logic [ACC_W-1:0]                      mcand_in,
  input  logic [pmsc_pkg::MPLIER_W-1:0]         mplier_in,
  input  logic [pmsc_pkg::SPAN_W+DUTY_BITS-1:0] dividend_in,
  input  logic [pmsc_pkg::SPAN_W-1:0]           divisor_in,
  output logic [ACC_W-1:0]                      acc,
  output logic [DUTY_BITS-1:0]                  quot,
  output logic                                  last
);

  localparam int NUM_W = pmsc_pkg::SPAN_W + DUTY_BITS;
  localparam int CNT_W = $clog2(pmsc_pkg::MPLIER_W + 1);

  logic [ACC_W-1:0]                mcand;
  logic [pmsc_pkg::MPLIER_W-1:0]   mplier;
  logic                            msigned;
  logic [CNT_W-1:0]                cnt;
  logic [pmsc_pkg::SPAN_W-1:0]     rem;
  logic [pmsc_pkg::SPAN_W-1:0]     den;
  logic [DUTY_BITS-1:0]            low;
  logic [pmsc_pkg::SPAN_W:0]       trial;
  logic                            trial_ok;
  logic [ACC_W-1:0]                sum;

  assign last = (cnt == CNT_W'(1));

  // The top multiplier bit of a signed operand carries negative weight.
  always_comb begin
    trial    = {rem, low[DUTY_BITS-1]};
    trial_ok = (trial >= {1'b0, den});
    if (msigned && last) begin
      sum = acc - mcand;
    end else begin
      sum = acc + mcand;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.load_mul) begin
      cnt <= CNT_W'(pmsc_pkg::MPLIER_W);
    end else if (ctrl.load_div) begin
      cnt <= CNT_W'(DUTY_BITS);
    end else if ((ctrl.mul_step || ctrl.div_step) && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc <= '0;
    end else if (ctrl.mul_step && mplier[0]) begin
      acc <= sum;
    end
    if (ctrl.load_mul) begin
      mcand   <= mcand_in;
      mplier  <= mplier_in;
      msigned <= ctrl.msigned;
    end else if (ctrl.mul_step) begin
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
    if (ctrl.load_div) begin
      rem  <= dividend_in[NUM_W-1:DUTY_BITS];
      low  <= dividend_in[DUTY_BITS-1:0];
      den  <= divisor_in;
      quot <= '0;
    end else if (ctrl.div_step) begin
      rem  <= trial_ok ? pmsc_pkg::SPAN_W'(trial - {1'b0, den})
                       : trial[pmsc_pkg::SPAN_W-1:0];
      low  <= low << 1;
      quot <= {quot[DUTY_BITS-2:0], trial_ok};
    end
  end

endmodule

>>> rtl/core/pid_motor_speed_controller.sv
// Top level of the motor speed PID controller with its event sequencer.
// Encoder, target, brake and idle tick items go from acceptance straight to the report state.
// A tick that runs a PID step passes through three 16-step serial products and, unless the
// duty saturates, a 16-step scaling product and a one-bit-a-cycle divider before its report;
// the next item is taken as its result is offered, and a result left waiting holds the next
// report. Reset clears the tracking state and returns the configuration to its defaults.
`timescale 1ns / 1ps

module pid_motor_speed_controller #(
  parameter int COUNT_BITS    = 16,
  parameter int DUTY_MAX      = 1023,
  parameter int INTEGRAL_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // target_signed, cycle_budget, brake_request, zero padding
  input  logic [((pmsc_pkg::TGT_W + pmsc_pkg::BUDGET_W + 1 + 7) / 8) * 8 - 1:0] s_tdata,
  // func
  input  logic [pmsc_pkg::FUNC_W-1:0]       s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // duty, reverse_line, braking, measured_ticks, cycles_left, zero padding
  output logic [(($clog2(DUTY_MAX + 1) + 2 + pmsc_pkg::MEAS_W + pmsc_pkg::BUDGET_W + 7)
                 / 8) * 8 - 1:0]              m_tdata,
  // duty_updated
  output logic [0:0]                        m_tuser,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pmsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pmsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int DB      = $clog2(DUTY_MAX + 1);
  localparam int MAG_W   = pmsc_pkg::TGT_W;
  localparam int EW      = ((COUNT_BITS > MAG_W) ? COUNT_BITS : MAG_W) + 1;
  localparam int DW      = EW + 1;
  localparam int OPW     = (INTEGRAL_BITS > DW) ? INTEGRAL_BITS : DW;
  localparam int SUM_W   = pmsc_pkg::GAIN_W + OPW + 2;
  localparam int NUM_W   = pmsc_pkg::SPAN_W + DB;
  localparam int ACC_W   = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int QW      = ACC_W - pmsc_pkg::FRAC_BITS;
  localparam int IW      = ((INTEGRAL_BITS > EW) ? INTEGRAL_BITS : EW) + 1;
  localparam int OUT_PAD = ((DB + 2 + pmsc_pkg::MEAS_W + pmsc_pkg::BUDGET_W + 7) / 8) * 8;
  localparam int TB_LO   = pmsc_pkg::TGT_W;
  localparam int BR_BIT  = pmsc_pkg::TGT_W + pmsc_pkg::BUDGET_W;

  localparam logic signed [IW-1:0] INT_MAX = IW'({1'b0, {(INTEGRAL_BITS-1){1'b1}}});
  localparam logic signed [IW-1:0] INT_MIN = ~INT_MAX;

  pmsc_pkg::state_t    state, state_next;
  pmsc_pkg::alu_ctrl_t ctrl;
  pmsc_pkg::func_t     func;

  logic signed [pmsc_pkg::GAIN_W-1:0] gain_p, gain_i, gain_d;
  logic signed [pmsc_pkg::SPAN_W-1:0] sum_floor, sum_ceiling;

  logic [COUNT_BITS-1:0]            edge_count;
  logic [MAG_W-1:0]                 target_magnitude;
  logic                             direction;
  logic [pmsc_pkg::BUDGET_W-1:0]    periods_remaining;
  logic signed [INTEGRAL_BITS-1:0]  error_integral;
  logic signed [EW-1:0]             previous_error;
  logic                             brake_engaged;
  logic [DB-1:0]                    last_duty;
  logic [COUNT_BITS-1:0]            last_measured;

  logic signed [EW-1:0]             e_r;
  logic signed [INTEGRAL_BITS-1:0]  integ_r;
  logic signed [DW-1:0]             de_r;
  logic [1:0]                       k;
  logic signed [QW-1:0]             q_r;
  logic                             f_ge_lo, f_le_lo, f_ge_hi, f_le_hi, f_up, f_eq;
  logic [pmsc_pkg::SPAN_W-1:0]      den_r;
  logic [DB-1:0]                    dnew;
  logic                             upd_r;

  logic                             accept;
  logic                             out_load;
  logic                             pid_go;
  logic signed [pmsc_pkg::TGT_W-1:0] tgt;
  logic signed [pmsc_pkg::TGT_W:0]  tgt_neg;
  logic signed [EW-1:0]             e_next;
  logic signed [IW-1:0]             isum;
  logic signed [INTEGRAL_BITS-1:0]  integ_sat;
  logic signed [DW-1:0]             de_next;
  logic signed [ACC_W-1:0]          acc_sh;
  logic signed [QW-1:0]             q_c;
  logic signed [QW-1:0]             lo_q, hi_q;
  logic signed [QW-1:0]             d_up, d_dn;
  logic [pmsc_pkg::SPAN_W-1:0]      num, den;
  logic                             sat_zero, sat_full;
  logic [ACC_W-1:0]                 mcand_sel;
  logic [pmsc_pkg::MPLIER_W-1:0]    mplier_sel;
  logic [ACC_W-1:0]                 acc;
  logic [DB-1:0]                    quot;
  logic                             alu_last;

  assign cfg_ready = 1'b1;
  assign func      = pmsc_pkg::func_t'(s_tuser);
  assign accept    = s_tvalid && s_tready;
  assign out_load  = (state == pmsc_pkg::S_REPORT) && (!m_tvalid || m_tready);
  assign pid_go    = (func == pmsc_pkg::FUNC_TICK) && !brake_engaged && (periods_remaining != '0);
  assign tgt       = $signed(s_tdata[pmsc_pkg::TGT_W-1:0]);
  assign tgt_neg   = -((pmsc_pkg::TGT_W + 1)'(tgt));

  always_comb begin
    e_next = $signed({{(EW-MAG_W){1'b0}}, target_magnitude})
           - $signed({{(EW-COUNT_BITS){1'b0}}, edge_count});
    isum   = IW'(error_integral) + IW'(e_r);
    if (isum > INT_MAX) begin
      integ_sat = INTEGRAL_BITS'(INT_MAX);
    end else if (isum < INT_MIN) begin
      integ_sat = INTEGRAL_BITS'(INT_MIN);
    end else begin
      integ_sat = INTEGRAL_BITS'(isum);
    end
    de_next = DW'(e_r) - DW'(previous_error);
    acc_sh  = $signed(acc) >>> pmsc_pkg::FRAC_BITS;
    q_c     = $signed(acc_sh[QW-1:0]);
    lo_q    = QW'(sum_floor);
    hi_q    = QW'(sum_ceiling);
    d_up    = q_r - lo_q;
    d_dn    = lo_q - q_r;
    num     = f_up ? d_up[pmsc_pkg::SPAN_W-1:0] : d_dn[pmsc_pkg::SPAN_W-1:0];
    den     = f_up ? pmsc_pkg::SPAN_W'(sum_ceiling - sum_floor)
                   : pmsc_pkg::SPAN_W'(sum_floor - sum_ceiling);
    if (f_eq) begin
      sat_full = f_ge_lo;
      sat_zero = !f_ge_lo;
    end else if (f_up) begin
      sat_zero = f_le_lo;
      sat_full = !f_le_lo && f_ge_hi;
    end else begin
      sat_zero = f_ge_lo;
      sat_full = !f_ge_lo && f_le_hi;
    end
  end

  always_comb begin
    case (k)
      2'd0: begin
        mcand_sel  = ACC_W'(e_r);
        mplier_sel = gain_p;
      end
      2'd1: begin
        mcand_sel  = ACC_W'(integ_r);
        mplier_sel = gain_i;
      end
      default: begin
        mcand_sel  = ACC_W'(de_r);
        mplier_sel = gain_d;
      end
    endcase
    if (state == pmsc_pkg::S_RNG) begin
      mcand_sel  = ACC_W'(num);
      mplier_sel = pmsc_pkg::MPLIER_W'(DUTY_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmsc_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    s_tready   = 1'b0;
    unique case (state)
      pmsc_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (accept) begin
          state_next = pid_go ? pmsc_pkg::S_ERR : pmsc_pkg::S_REPORT;
        end
      end
      pmsc_pkg::S_ERR: begin
        state_next = pmsc_pkg::S_INT;
      end
      pmsc_pkg::S_INT: begin
        ctrl.clear = 1'b1;
        state_next = pmsc_pkg::S_LOAD;
      end
      pmsc_pkg::S_LOAD: begin
        ctrl.load_mul = 1'b1;
        ctrl.msigned  = 1'b1;
        state_next    = pmsc_pkg::S_MUL;
      end
      pmsc_pkg::S_MUL: begin
        ctrl.mul_step = 1'b1;
        if (alu_last) begin
          state_next = (k == 2'(pmsc_pkg::TERMS - 1)) ? pmsc_pkg::S_CMP : pmsc_pkg::S_LOAD;
        end
      end
      pmsc_pkg::S_CMP: begin
        state_next = pmsc_pkg::S_RNG;
      end
      pmsc_pkg::S_RNG: begin
        if (sat_zero || sat_full) begin
          state_next = pmsc_pkg::S_DONE;
        end else begin
          ctrl.clear    = 1'b1;
          ctrl.load_mul = 1'b1;
          state_next    = pmsc_pkg::S_SCALE;
        end
      end
      pmsc_pkg::S_SCALE: begin
        ctrl.mul_step = 1'b1;
        if (alu_last) begin
          state_next = pmsc_pkg::S_DIVLD;
        end
      end
      pmsc_pkg::S_DIVLD: begin
        ctrl.load_div = 1'b1;
        state_next    = pmsc_pkg::S_DIV;
      end
      pmsc_pkg::S_DIV: begin
        ctrl.div_step = 1'b1;
        if (alu_last) begin
          state_next = pmsc_pkg::S_QUOT;
        end
      end
      pmsc_pkg::S_QUOT: begin
        state_next = pmsc_pkg::S_DONE;
      end
      pmsc_pkg::S_DONE: begin
        state_next = pmsc_pkg::S_REPORT;
      end
      pmsc_pkg::S_REPORT: begin
        if (out_load) begin
          state_next = pmsc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pmsc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p      <= pmsc_pkg::GAIN_P_RESET;
      gain_i      <= '0;
      gain_d      <= '0;
      sum_floor   <= '0;
      sum_ceiling <= pmsc_pkg::SUM_CEILING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pmsc_pkg::REG_GAIN_P:      gain_p      <= $signed(cfg_data[pmsc_pkg::GAIN_W-1:0]);
        pmsc_pkg::REG_GAIN_I:      gain_i      <= $signed(cfg_data[pmsc_pkg::GAIN_W-1:0]);
        pmsc_pkg::REG_GAIN_D:      gain_d      <= $signed(cfg_data[pmsc_pkg::GAIN_W-1:0]);
        pmsc_pkg::REG_SUM_FLOOR:   sum_floor   <= $signed(cfg_data[pmsc_pkg::SPAN_W-1:0]);
        pmsc_pkg::REG_SUM_CEILING: sum_ceiling <= $signed(cfg_data[pmsc_pkg::SPAN_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count        <= '0;
      target_magnitude  <= '0;
      direction         <= 1'b0;
      periods_remaining <= '0;
      error_integral    <= '0;
      previous_error    <= '0;
      brake_engaged     <= 1'b0;
      last_duty         <= '0;
      last_measured     <= '0;
      upd_r             <= 1'b0;
    end else if (state == pmsc_pkg::S_IDLE && accept) begin
      upd_r <= 1'b0;
      case (func)
        pmsc_pkg::FUNC_EDGE: begin
          edge_count <= edge_count + 1'b1;
        end
        pmsc_pkg::FUNC_TARGET: begin
          direction         <= !(tgt > 0);
          target_magnitude  <= (tgt > 0) ? tgt[MAG_W-1:0] : tgt_neg[MAG_W-1:0];
          periods_remaining <= s_tdata[BR_BIT-1:TB_LO];
        end
        pmsc_pkg::FUNC_BRAKE: begin
          brake_engaged <= s_tdata[BR_BIT];
        end
        default: begin
        end
      endcase
    end else if (state == pmsc_pkg::S_DONE) begin
      upd_r             <= 1'b1;
      error_integral    <= integ_r;
      previous_error    <= e_r;
      last_duty         <= dnew;
      last_measured     <= edge_count;
      edge_count        <= '0;
      periods_remaining <= periods_remaining - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      pmsc_pkg::S_ERR: begin
        e_r <= e_next;
      end
      pmsc_pkg::S_INT: begin
        integ_r <= integ_sat;
        de_r    <= de_next;
        k       <= '0;
      end
      pmsc_pkg::S_MUL: begin
        if (alu_last) begin
          k <= k + 1'b1;
        end
      end
      pmsc_pkg::S_CMP: begin
        q_r     <= q_c;
        f_ge_lo <= (q_c >= lo_q);
        f_le_lo <= (q_c <= lo_q);
        f_ge_hi <= (q_c >= hi_q);
        f_le_hi <= (q_c <= hi_q);
        f_up    <= (sum_floor < sum_ceiling);
        f_eq    <= (sum_floor == sum_ceiling);
      end
      pmsc_pkg::S_RNG: begin
        den_r <= den;
        dnew  <= sat_full ? DB'(DUTY_MAX) : '0;
      end
      pmsc_pkg::S_QUOT: begin
        dnew <= quot;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= OUT_PAD'({periods_remaining, pmsc_pkg::MEAS_W'(last_measured),
                           brake_engaged, direction, last_duty});
      m_tuser <= upd_r;
    end
  end

  pmsc_alu #(
    .ACC_W     (ACC_W),
    .DUTY_BITS (DB)
  ) u_alu (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .mcand_in    (mcand_sel),
    .mplier_in   (mplier_sel),
    .dividend_in (acc[NUM_W-1:0]),
    .divisor_in  (den_r),
    .acc         (acc),
    .quot        (quot),
    .last        (alu_last)
  );

endmodule

>>> rtl/core/pmsc_checker.sv
// Port-level assertions for the motor speed controller and their binding.
`timescale 1ns / 1ps
`include "pid_motor_speed_controller_defines.svh"

module pmsc_checker #(
  parameter int DUTY_MAX = 1023
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [(($clog2(DUTY_MAX + 1) + 2 + pmsc_pkg::MEAS_W + pmsc_pkg::BUDGET_W + 7)
                / 8) * 8 - 1:0] m_tdata,
  input logic [0:0]             m_tuser
);

  localparam int BRAKE_BIT = $clog2(DUTY_MAX + 1) + 1;

  `PMSC_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output item changed")
  `PMSC_ASSERT_NEXT(a_busy_after_take, clk, rst, s_tvalid && s_tready, !s_tready, "second item taken before first finished")
  `PMSC_ASSERT_NOW(a_update_not_braking, clk, rst, m_tvalid && m_tuser[0], !m_tdata[BRAKE_BIT], "duty update reported while braking")

endmodule

bind pid_motor_speed_controller pmsc_checker #(
  .DUTY_MAX (DUTY_MAX)
) u_pmsc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

>>> test/pid_motor_speed_controller_tb.sv
// Self-checking testbench for the motor speed PID controller with its own status predictor.
`timescale 1ns / 1ps

module pid_motor_speed_controller_tb;

  localparam int DUTY_MAX = 1023;
  localparam int IN_BITS  = ((pmsc_pkg::TGT_W + pmsc_pkg::BUDGET_W + 1 + 7) / 8) * 8;
  localparam int OUT_BITS = (($clog2(DUTY_MAX + 1) + 2 + pmsc_pkg::MEAS_W + pmsc_pkg::BUDGET_W
                              + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 3000000;
  localparam longint INTEG_MAX = 64'sd2147483647;
  localparam longint INTEG_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [9:0]  duty;
    logic        reverse;
    logic        braking;
    logic        updated;
    logic [15:0] measured;
    logic [15:0] left;
  } status_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [IN_BITS-1:0]              s_tdata = '0;
  logic [pmsc_pkg::FUNC_W-1:0]     s_tuser = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [OUT_BITS-1:0]             m_tdata;
  logic [0:0]                      m_tuser;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [pmsc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [pmsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  pid_motor_speed_controller dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predicted controller state and register copies.
  longint      kp = 256, ki = 0, kd = 0, floor_sum = 0, ceil_sum = 65535;
  logic [15:0] edges = '0, target_mag = '0, periods_left = '0, last_meas = '0;
  logic        reverse_dir = 1'b0, brake_on = 1'b0;
  longint      integral = 0, prev_error = 0;
  logic [9:0]  last_duty = '0;

  status_t expected_status[$];
  status_t want;
  int      errors = 0;
  int      cycles = 0;
  int      sent_items = 0;
  int      send_idle_pct = 19;
  int      recv_idle_pct = 80;
  int      stall_request = 0;
  int      stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_request != 0) begin
      stall_left = stall_request;
      stall_request = 0;
    end
    if (stall_left != 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic status_t predict_status(pmsc_pkg::func_t f, logic signed [15:0] tgt,
                                             logic [15:0] budget, logic brake_req);
    status_t r;
    longint  err, sum, q, num, den;
    r.updated = 1'b0;
    case (f)
      pmsc_pkg::FUNC_EDGE: begin
        edges = edges + 16'd1;
      end
      pmsc_pkg::FUNC_TICK: begin
        if (!brake_on && periods_left != 0) begin
          err = target_mag;
          err = err - edges;
          integral = integral + err;
          if (integral > INTEG_MAX) integral = INTEG_MAX;
          if (integral < INTEG_MIN) integral = INTEG_MIN;
          sum = kp * err + ki * integral + kd * (err - prev_error);
          q = sum >>> 8;
          if (floor_sum == ceil_sum) begin
            last_duty = (q >= floor_sum) ? 10'(DUTY_MAX) : 10'd0;
          end else if (floor_sum < ceil_sum) begin
            num = q - floor_sum;
            den = ceil_sum - floor_sum;
            if (q <= floor_sum) last_duty = 10'd0;
            else if (q >= ceil_sum) last_duty = 10'(DUTY_MAX);
            else last_duty = 10'(num * DUTY_MAX / den);
          end else begin
            num = floor_sum - q;
            den = floor_sum - ceil_sum;
            if (q >= floor_sum) last_duty = 10'd0;
            else if (q <= ceil_sum) last_duty = 10'(DUTY_MAX);
            else last_duty = 10'(num * DUTY_MAX / den);
          end
          prev_error = err;
          last_meas = edges;
          edges = '0;
          periods_left = periods_left - 16'd1;
          r.updated = 1'b1;
        end
      end
      pmsc_pkg::FUNC_TARGET: begin
        reverse_dir = (tgt <= 0);
        target_mag = (tgt > 0) ? 16'(tgt) : 16'(-tgt);
        periods_left = budget;
      end
      default: begin
        brake_on = brake_req;
      end
    endcase
    r.duty = last_duty;
    r.reverse = reverse_dir;
    r.braking = brake_on;
    r.measured = last_meas;
    r.left = periods_left;
    return r;
  endfunction

  task automatic check_field(string name, longint exp_val, longint got_val);
    if (exp_val != got_val) begin
      errors++;
      $display("%0t ns: %s expected %0d actual %0d", $time, name, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_status.size() == 0) begin
        errors++;
        $display("%0t ns: result expected none actual %h/%b", $time, m_tdata, m_tuser);
      end else begin
        want = expected_status.pop_front();
        check_field("duty", want.duty, m_tdata[9:0]);
        check_field("reverse_line", want.reverse, m_tdata[10]);
        check_field("braking", want.braking, m_tdata[11]);
        check_field("duty_updated", want.updated, m_tuser[0]);
        check_field("measured_ticks", want.measured, m_tdata[27:12]);
        check_field("cycles_left", want.left, m_tdata[43:28]);
      end
    end
  end

  // Called at a falling edge; leaves tvalid high so that items can follow back to back.
  task automatic send_item(pmsc_pkg::func_t f, logic signed [15:0] tgt, logic [15:0] budget,
                           logic brake_req);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= IN_BITS'({brake_req, budget, tgt});
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_status.push_back(predict_status(f, tgt, budget, brake_req));
    sent_items++;
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [pmsc_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pmsc_pkg::REG_GAIN_P:      kp = signed'(value[15:0]);
      pmsc_pkg::REG_GAIN_I:      ki = signed'(value[15:0]);
      pmsc_pkg::REG_GAIN_D:      kd = signed'(value[15:0]);
      pmsc_pkg::REG_SUM_FLOOR:   floor_sum = signed'(value);
      pmsc_pkg::REG_SUM_CEILING: ceil_sum = signed'(value);
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(int p, int i, int d, int lo, int hi);
    write_reg(pmsc_pkg::REG_GAIN_P, 32'(p));
    write_reg(pmsc_pkg::REG_GAIN_I, 32'(i));
    write_reg(pmsc_pkg::REG_GAIN_D, 32'(d));
    write_reg(pmsc_pkg::REG_SUM_FLOOR, 32'(lo));
    write_reg(pmsc_pkg::REG_SUM_CEILING, 32'(hi));
  endtask

  task automatic test_directed_events();
    send_item(pmsc_pkg::FUNC_TICK, 16'sd0, 16'd0, 1'b0);
    send_item(pmsc_pkg::FUNC_BRAKE, -16'sd1, 16'hFFFF, 1'b1);
    send_item(pmsc_pkg::FUNC_TICK, 16'sd0, 16'd0, 1'b0);
    send_item(pmsc_pkg::FUNC_TARGET, 16'sd5, 16'd3, 1'b0);
    send_item(pmsc_pkg::FUNC_TICK, 16'sd0, 16'd0, 1'b1);
    send_item(pmsc_pkg::FUNC_BRAKE, 16'sd0, 16'd0, 1'b0);
    send_item(pmsc_pkg::FUNC_EDGE, 16'sd0, 16'd0, 1'b0);
    send_item(pmsc_pkg::FUNC_EDGE, 16'sd0, 16'd0, 1'b0);
    send_item(pmsc_pkg::FUNC_TICK, 16'sd0, 16'd0, 1'b0);
    send_item(pmsc_pkg::FUNC_TICK, 16'sd0, 16'd0, 1'b0);
    send_item(pmsc_pkg::FUNC_TARGET, 16'sd0, 16'd2, 1'b0);
    send_item(pmsc_pkg::FUNC_TICK, 16'sd0, 16'd0, 1'b0);
    send_item(pmsc_pkg::FUNC_TARGET, -16'sd32768, 16'hFFFF, 1'b0);
    send_item(pmsc_pkg::FUNC_EDGE, 16'sd0, 16'd0, 1'b0);
    send_item(pmsc_pkg::FUNC_TICK, 16'sd0, 16'd0, 1'b0);
    send_item(pmsc_pkg::FUNC_TARGET, 16'sd32767, 16'd0, 1'b0);
    send_item(pmsc_pkg::FUNC_TICK, 16'sd0, 16'd0, 1'b0);
    drain();
  endtask

  task automatic run_short_target(logic signed [15:0] tgt, int n_edges);
    send_item(pmsc_pkg::FUNC_TARGET, tgt, 16'd2, 1'b0);
    repeat (n_edges) send_item(pmsc_pkg::FUNC_EDGE, 16'sd0, 16'd0, 1'b0);
    send_item(pmsc_pkg::FUNC_TICK, 16'sd0, 16'd0, 1'b0);
    send_item(pmsc_pkg::FUNC_TICK, 16'sd0, 16'd0, 1'b0);
    drain();
  endtask

  task automatic test_map_ranges();
    // Falling map: the ceiling below the floor.
    set_config(256, 16, -64, 500, -500);
    run_short_target(-16'sd300, 1);
    // Floor and ceiling equal.
    set_config(256, 0, 0, 0, 0);
    run_short_target(16'sd3, 1);
    // Widest span with the largest gains, both ways round.
    set_config(-32768, 32767, -32768, 32'h8000_0000, 32'h7FFF_FFFF);
    run_short_target(16'sd32767, 0);
    set_config(32767, -32768, 32767, 32'h7FFF_FFFF, 32'h8000_0000);
    run_short_target(-16'sd32768, 0);
  endtask

  task automatic test_random_traffic(int style, int count);
    int                 first;
    int                 lo;
    int                 hi;
    logic signed [15:0] tgt;
    logic [15:0]        budget;
    lo = $urandom_range(2000);
    hi = $urandom_range(2000) + 1;
    case (style)
      0: set_config($urandom_range(1024) - 256, $urandom_range(64) - 32,
                    $urandom_range(512) - 256, -lo, hi);
      1: set_config($urandom_range(1024) - 256, $urandom_range(64) - 32,
                    $urandom_range(512) - 256, lo, -hi);
      default: set_config($urandom, $urandom, $urandom, $urandom, $urandom);
    endcase
    first = sent_items;
    while (sent_items < first + count) begin
      if ($urandom_range(99) < 85) begin
        if (brake_on) begin
          send_item(pmsc_pkg::FUNC_BRAKE, 16'($urandom), 16'($urandom), 1'b0);
        end
        tgt = ($urandom_range(99) < 70) ? 16'($urandom_range(400)) - 16'sd200
                                        : 16'($urandom);
        budget = ($urandom_range(99) < 80) ? 16'($urandom_range(12, 1)) : 16'($urandom);
        send_item(pmsc_pkg::FUNC_TARGET, tgt, budget, 1'($urandom));
        repeat ($urandom_range(8, 1)) begin
          repeat ($urandom_range(12))
            send_item(pmsc_pkg::FUNC_EDGE, 16'($urandom), 16'($urandom), 1'($urandom));
          if ($urandom_range(9) == 0) begin
            send_item(pmsc_pkg::FUNC_BRAKE, 16'($urandom), 16'($urandom), 1'b1);
            send_item(pmsc_pkg::FUNC_TICK, 16'($urandom), 16'($urandom), 1'($urandom));
            send_item(pmsc_pkg::FUNC_BRAKE, 16'($urandom), 16'($urandom), 1'b0);
          end
          send_item(pmsc_pkg::FUNC_TICK, 16'($urandom), 16'($urandom), 1'($urandom));
        end
      end else begin
        send_item(pmsc_pkg::func_t'($urandom_range(3)), 16'($urandom), 16'($urandom),
                  1'($urandom));
      end
    end
    drain();
  endtask

  task automatic test_backpressure();
    stall_request = 400;
    send_item(pmsc_pkg::FUNC_TARGET, 16'sd50, 16'd20, 1'b0);
    repeat (40) begin
      send_item(($urandom_range(3) == 0) ? pmsc_pkg::FUNC_TICK : pmsc_pkg::FUNC_EDGE,
                16'($urandom), 16'($urandom), 1'($urandom));
    end
    drain();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_events();
    test_map_ranges();
    send_idle_pct = 19;
    recv_idle_pct = 80;
    test_random_traffic(0, 500);
    send_idle_pct = 80;
    recv_idle_pct = 19;
    test_random_traffic(1, 500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(2, 500);
    test_backpressure();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
